// ===== sv/fbre_pkg.sv =====
package fbre_pkg;

	localparam int ScreenWidth = 240;
	localparam int BandRows    = 80;
	localparam int StoreSize   = ScreenWidth * BandRows;
	localparam int AddrW       = $clog2(StoreSize);
	localparam int CoordW      = 9;
	// signed working width for coordinates, offsets and error terms
	localparam int SW          = 13;
	localparam int ColorW      = 16;

	typedef logic signed [SW-1:0] scoord_t;

	typedef enum logic [2:0] {
		MODE_CLEAR  = 3'd0,
		MODE_PIXEL  = 3'd1,
		MODE_RECT   = 3'd2,
		MODE_LINE   = 3'd3,
		MODE_CIRCLE = 3'd4,
		MODE_FILL   = 3'd5,
		MODE_READ   = 3'd6
	} mode_t;

	// one write request from the sequencer to the clipping/address unit
	typedef struct packed {
		logic             valid;
		scoord_t          x;
		scoord_t          y;
		logic [ColorW-1:0] color;
	} px_req_t;

	// linear (row-major) address of a pixel in the store
	function automatic logic [AddrW-1:0] px_addr(input logic [CoordW-1:0] x,
		input logic [CoordW-1:0] y);
		logic [AddrW+CoordW-1:0] p;
		p = AddrW'(y) * (AddrW+CoordW)'(ScreenWidth) + (AddrW+CoordW)'(x);
		return p[AddrW-1:0];
	endfunction

endpackage

// ===== sv/fbre_ram.sv =====
module fbre_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/fbre_clip.sv =====
module fbre_clip import fbre_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  px_req_t            req,
	output logic               we_s1,
	output logic [AddrW-1:0]   addr_s1,
	output logic [ColorW-1:0]  data_s1
);

	logic inside_w;

	// drop pixels outside the band
	assign inside_w = !req.x[SW-1] && !req.y[SW-1] &&
		(req.x < scoord_t'(ScreenWidth)) && (req.y < scoord_t'(BandRows));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1 <= 1'b0;
		end else begin
			we_s1 <= req.valid && inside_w;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= px_addr(req.x[CoordW-1:0], req.y[CoordW-1:0]);
		data_s1 <= req.color;
	end

endmodule

// ===== sv/framebuffer_raster_engine.sv =====
// Drawing command engine over a 240 x 80 band of 16-bit pixels. A command is
// taken when start is high and busy is low; busy then stays high while the
// sequencer walks the command one pixel per cycle through one store write
// port. A clear sweeps the whole store, a rectangle walks its clipped pixels,
// a line its pixels, a circle outline eight octant points per step of the
// midpoint walk, a filled circle four spans per step (unclipped); every
// command ends in a drain state that lets the last write land. After reset
// the store is swept to zero with busy high. Each command gives exactly one
// result: done pulses for one cycle with read_color, which is zero except in
// read mode. The receiver cannot hold results off; sample read_color whenever
// done is high.
module framebuffer_raster_engine import fbre_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	input  logic [2:0]          mode,
	input  logic [CoordW-1:0]   x_start,
	input  logic [CoordW-1:0]   y_start,
	input  logic [CoordW-1:0]   x_end,
	input  logic [CoordW-1:0]   y_end,
	input  logic [CoordW-1:0]   rect_width,
	input  logic [CoordW-1:0]   rect_height,
	input  logic [CoordW-1:0]   radius,
	input  logic [ColorW-1:0]   color,
	output logic [ColorW-1:0]   read_color
);

	typedef enum logic [8:0] {
		ST_INIT  = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_CLEAR = 9'b000000100,
		ST_RECT  = 9'b000001000,
		ST_LINE  = 9'b000010000,
		ST_CIRC  = 9'b000100000,
		ST_SPAN  = 9'b001000000,
		ST_READ  = 9'b010000000,
		ST_DRAIN = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [AddrW-1:0]    cnt_q;
	logic [ColorW-1:0]   color_q;
	scoord_t             cx_q, cy_q, xe_q, ye_q;
	scoord_t             px_q, py_q;      // walk position / circle x,y
	scoord_t             err_q;
	scoord_t             dx_q, dy_q;
	logic                sx_q, sy_q;      // 1 = negative step
	scoord_t             w_q, h_q;
	scoord_t             col_q, row_q;
	logic [2:0]          oct_q;           // outline octant or fill span index
	scoord_t             sa_q, sb_q, sy2_q; // current span
	logic [1:0]          drain_q;
	logic                rd_pend_q;
	logic                read_ok_q;

	px_req_t             req;
	logic                we_s1;
	logic [AddrW-1:0]    waddr_s1;
	logic [ColorW-1:0]   wdata_s1;
	logic [AddrW-1:0]    raddr;
	logic [ColorW-1:0]   rdata;
	logic                ram_we;
	logic [AddrW-1:0]    ram_waddr;
	logic [ColorW-1:0]   ram_wdata;

	// circle octant point
	scoord_t             ox, oy;
	scoord_t             e2;
	scoord_t             cerr1, cy1, cerr2, cx2;
	scoord_t             rw_c, rh_c;
	logic                circ_last;

	fbre_clip u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.we_s1   (we_s1),
		.addr_s1 (waddr_s1),
		.data_s1 (wdata_s1)
	);

	// store writes come from the clip stage, or straight from the sweep
	assign ram_we    = we_s1 || state_q == ST_INIT || state_q == ST_CLEAR;
	assign ram_waddr = (state_q == ST_INIT || state_q == ST_CLEAR) ? cnt_q : waddr_s1;
	assign ram_wdata = (state_q == ST_INIT) ? '0 :
		(state_q == ST_CLEAR) ? color_q : wdata_s1;
	// read address from the registered command, inputs may move after accept
	assign raddr     = px_addr(cx_q[CoordW-1:0], cy_q[CoordW-1:0]);

	fbre_ram #(.Width(ColorW), .Depth(StoreSize)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_we && (state_q == ST_INIT || state_q == ST_CLEAR) ? cnt_q : ram_waddr),
		.wdata (ram_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy = state_q != ST_IDLE;

	// outline point for the current octant
	always_comb begin
		case (oct_q)
			3'd0: begin ox = cx_q + px_q; oy = cy_q + py_q; end
			3'd1: begin ox = cx_q + py_q; oy = cy_q + px_q; end
			3'd2: begin ox = cx_q - py_q; oy = cy_q + px_q; end
			3'd3: begin ox = cx_q - px_q; oy = cy_q + py_q; end
			3'd4: begin ox = cx_q - px_q; oy = cy_q - py_q; end
			3'd5: begin ox = cx_q - py_q; oy = cy_q - px_q; end
			3'd6: begin ox = cx_q + py_q; oy = cy_q - px_q; end
			default: begin ox = cx_q + px_q; oy = cy_q - py_q; end
		endcase
	end

	// midpoint circle step
	always_comb begin
		cerr1 = err_q;
		cy1   = py_q;
		if (err_q <= 0) begin
			cy1   = py_q + scoord_t'(1);
			cerr1 = err_q + (cy1 <<< 1) + scoord_t'(1);
		end
		cx2   = px_q;
		cerr2 = cerr1;
		if (cerr1 > 0) begin
			cx2   = px_q - scoord_t'(1);
			cerr2 = cerr1 - (cx2 <<< 1) - scoord_t'(1);
		end
		circ_last = !(cx2 >= cy1);
	end

	assign e2 = err_q <<< 1;

	// rectangle clip
	always_comb begin
		rw_c = scoord_t'(rect_width);
		rh_c = scoord_t'(rect_height);
		if (scoord_t'(x_start) + rw_c > scoord_t'(ScreenWidth))
			rw_c = scoord_t'(ScreenWidth) - scoord_t'(x_start);
		if (scoord_t'(y_start) + rh_c > scoord_t'(BandRows))
			rh_c = scoord_t'(BandRows) - scoord_t'(y_start);
	end

	// pixel request
	always_comb begin
		req.valid = 1'b0;
		req.x     = px_q;
		req.y     = py_q;
		req.color = color_q;
		case (state_q)
			ST_RECT: begin
				req.valid = 1'b1;
				req.x = cx_q + col_q;
				req.y = cy_q + row_q;
			end
			ST_LINE: req.valid = 1'b1;
			ST_CIRC: begin
				req.valid = 1'b1;
				req.x = ox;
				req.y = oy;
			end
			ST_SPAN: begin
				req.valid = sa_q <= sb_q;
				req.x = sa_q;
				req.y = sy2_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			cnt_q     <= '0;
			drain_q   <= '0;
			done      <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			done      <= 1'b0;
			rd_pend_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					// power-up sweep gives no result
					if (cnt_q == AddrW'(StoreSize - 1)) begin
						state_q <= ST_IDLE;
					end
					cnt_q <= cnt_q + AddrW'(1);
				end
				ST_CLEAR: begin
					if (cnt_q == AddrW'(StoreSize - 1)) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end
					cnt_q <= cnt_q + AddrW'(1);
				end
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						drain_q <= '0;
						case (mode)
							MODE_CLEAR: state_q <= ST_CLEAR;
							MODE_PIXEL: state_q <= ST_LINE;
							MODE_RECT: begin
								if (x_start >= CoordW'(ScreenWidth) ||
									y_start >= CoordW'(BandRows) ||
									rw_c <= 0 || rh_c <= 0)
									state_q <= ST_DRAIN;
								else
									state_q <= ST_RECT;
							end
							MODE_LINE: state_q <= ST_LINE;
							MODE_CIRCLE: state_q <= ST_CIRC;
							MODE_FILL: state_q <= ST_SPAN;
							MODE_READ: state_q <= ST_READ;
							default: state_q <= ST_DRAIN;
						endcase
					end
				end
				ST_RECT: begin
					if (col_q == w_q - scoord_t'(1)) begin
						if (row_q == h_q - scoord_t'(1)) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_LINE: begin
					if (px_q == xe_q && py_q == ye_q) state_q <= ST_DRAIN;
				end
				ST_CIRC: begin
					if (oct_q == 3'd7 && circ_last) state_q <= ST_DRAIN;
				end
				ST_SPAN: begin
					if (sa_q >= sb_q && oct_q[1:0] == 2'd3 && circ_last)
						state_q <= ST_DRAIN;
				end
				ST_READ: begin
					rd_pend_q <= 1'b1;
					state_q   <= ST_DRAIN;
				end
				ST_DRAIN: begin
					// let the last write land before the next command
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd1) begin
						state_q <= ST_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				color_q   <= color;
				cx_q      <= scoord_t'(x_start);
				cy_q      <= scoord_t'(y_start);
				xe_q      <= (mode == MODE_PIXEL) ? scoord_t'(x_start) : scoord_t'(x_end);
				ye_q      <= (mode == MODE_PIXEL) ? scoord_t'(y_start) : scoord_t'(y_end);
				w_q       <= rw_c;
				h_q       <= rh_c;
				col_q     <= '0;
				row_q     <= '0;
				oct_q     <= '0;
				read_ok_q <= mode == MODE_READ && x_start < CoordW'(ScreenWidth) &&
					y_start < CoordW'(BandRows);
				read_color <= '0;
				err_q     <= '0;
				if (mode == MODE_CIRCLE || mode == MODE_FILL) begin
					px_q <= scoord_t'(radius);
					py_q <= '0;
					sa_q <= scoord_t'(x_start) - scoord_t'(radius);
					sb_q <= scoord_t'(x_start) + scoord_t'(radius);
					sy2_q <= scoord_t'(y_start);
				end else begin
					px_q <= scoord_t'(x_start);
					py_q <= scoord_t'(y_start);
					dx_q <= (x_end > x_start) ? scoord_t'(x_end) - scoord_t'(x_start)
						: scoord_t'(x_start) - scoord_t'(x_end);
					dy_q <= (y_end > y_start) ? scoord_t'(y_end) - scoord_t'(y_start)
						: scoord_t'(y_start) - scoord_t'(y_end);
					sx_q <= !(x_start < x_end);
					sy_q <= !(y_start < y_end);
					err_q <= ((x_end > x_start) ? scoord_t'(x_end) - scoord_t'(x_start)
						: scoord_t'(x_start) - scoord_t'(x_end)) -
						((y_end > y_start) ? scoord_t'(y_end) - scoord_t'(y_start)
						: scoord_t'(y_start) - scoord_t'(y_end));
				end
			end
			ST_RECT: begin
				if (col_q == w_q - scoord_t'(1)) begin
					col_q <= '0;
					row_q <= row_q + scoord_t'(1);
				end else begin
					col_q <= col_q + scoord_t'(1);
				end
			end
			ST_LINE: begin
				if (e2 > -dy_q && e2 < dx_q) begin
					err_q <= err_q - dy_q + dx_q;
				end else if (e2 > -dy_q) begin
					err_q <= err_q - dy_q;
				end else if (e2 < dx_q) begin
					err_q <= err_q + dx_q;
				end
				if (e2 > -dy_q) px_q <= sx_q ? px_q - scoord_t'(1) : px_q + scoord_t'(1);
				if (e2 < dx_q)  py_q <= sy_q ? py_q - scoord_t'(1) : py_q + scoord_t'(1);
			end
			ST_CIRC: begin
				oct_q <= oct_q + 3'd1;
				if (oct_q == 3'd7) begin
					px_q  <= cx2;
					py_q  <= cy1;
					err_q <= cerr2;
				end
			end
			ST_SPAN: begin
				if (sa_q >= sb_q) begin
					// next of the four spans, then advance the circle
					oct_q <= {1'b0, oct_q[1:0] + 2'd1};
					if (oct_q[1:0] == 2'd3) begin
						px_q  <= cx2;
						py_q  <= cy1;
						err_q <= cerr2;
						sa_q  <= cx_q - cx2;
						sb_q  <= cx_q + cx2;
						sy2_q <= cy_q + cy1;
					end else begin
						case (oct_q[1:0])
							2'd0: begin
								sa_q <= cx_q - px_q; sb_q <= cx_q + px_q;
								sy2_q <= cy_q - py_q;
							end
							2'd1: begin
								sa_q <= cx_q - py_q; sb_q <= cx_q + py_q;
								sy2_q <= cy_q + px_q;
							end
							default: begin
								sa_q <= cx_q - py_q; sb_q <= cx_q + py_q;
								sy2_q <= cy_q - px_q;
							end
						endcase
					end
				end else begin
					sa_q <= sa_q + scoord_t'(1);
				end
			end
			ST_DRAIN: begin
				if (rd_pend_q && read_ok_q) read_color <= rdata;
			end
			default: ;
		endcase
	end

endmodule
